>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated by the active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/flwnm_pkg.sv
package flwnm_pkg;

	localparam int unsigned STR_BYTES = 16;
	localparam int unsigned LEN_W     = 5;
	localparam int unsigned IDX_W     = 4;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_QMARK = 8'h3F;

	// Register select: bit 3 of the byte address picks the 64-bit register.
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned ADDR_SEL = 3;
	localparam logic REG_PAT_LOW  = 1'b0;
	localparam logic REG_PAT_HIGH = 1'b1;

	typedef logic [STR_BYTES-1:0][7:0] str_t;
	typedef logic [LEN_W-1:0]          len_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [STR_BYTES-1:0]      lane_vec_t;

	typedef struct packed {
		logic empty;
		logic star;
		len_t plen;
		len_t nlen;
	} merge_ctrl_t;

	// Position of the first NUL, or the full width when there is none.
	function automatic len_t str_len(input str_t s);
		len_t n;
		n = len_t'(STR_BYTES);
		for (int i = STR_BYTES - 1; i >= 0; i--) begin
			if (s[i] == CHAR_NUL) begin
				n = len_t'(i);
			end
		end
		return n;
	endfunction

endpackage

>>> design/flwnm_lane.sv
module flwnm_lane (
	input  flwnm_pkg::idx_t lane_idx,
	input  logic [7:0]      pat_pos,
	input  logic [7:0]      name_pos,
	input  logic [7:0]      pat_star,
	input  flwnm_pkg::str_t name,
	input  flwnm_pkg::idx_t start,
	output logic            pos_ok,
	output logic            star_ok
);

	flwnm_pkg::idx_t sel;

	// tail lanes line up with the name's last bytes; wrap is harmless, masked later
	assign sel     = start + lane_idx;
	assign pos_ok  = (pat_pos == flwnm_pkg::CHAR_QMARK) || (pat_pos == name_pos);
	assign star_ok = (pat_star == name[sel]);

endmodule

>>> design/flwnm_merge.sv
module flwnm_merge (
	input  flwnm_pkg::merge_ctrl_t ctrl,
	input  flwnm_pkg::lane_vec_t   pos_ok,
	input  flwnm_pkg::lane_vec_t   star_ok,
	output logic                   matched
);

	flwnm_pkg::len_t      tail;
	flwnm_pkg::lane_vec_t pos_mask;
	flwnm_pkg::lane_vec_t star_mask;
	logic                 pos_hit;
	logic                 star_hit;

	assign tail = ctrl.plen - flwnm_pkg::len_t'(1);

	always_comb begin
		for (int i = 0; i < flwnm_pkg::STR_BYTES; i++) begin
			pos_mask[i]  = flwnm_pkg::len_t'(i) < ctrl.plen;
			star_mask[i] = flwnm_pkg::len_t'(i) < tail;
		end
	end

	assign pos_hit  = (ctrl.plen == ctrl.nlen) && (&(pos_ok | ~pos_mask));
	assign star_hit = (tail == '0) || ((tail <= ctrl.nlen) && (&(star_ok | ~star_mask)));
	assign matched  = ctrl.empty || (ctrl.star ? star_hit : pos_hit);

endmodule

>>> design/fixed_length_wildcard_name_match.sv
// Throughput: one name per cycle while the output is not stalled; stage 1 finds
// the name length, stage 2 runs 16 byte lanes (exact/'?' and '*'-suffix compares),
// and stage 3 merges into the output register.
// Each stage holds its beat independently, so bubbles close up under back-pressure.
// Reset (arst_n low, asynchronous): valid flags clear and the pattern returns
// to empty, so every name matches until the pattern is written.
module fixed_length_wildcard_name_match (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config port, APB style
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [flwnm_pkg::ADDR_W-1:0]         paddr,
	input  logic [63:0]                          pwdata,
	output logic [63:0]                          prdata,
	output logic                                 pready,
	// name beats
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [63:0]                          name_low,
	input  logic [63:0]                          name_high,
	// result beats
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 matched
);

	// ---------------- pattern registers ----------------
	logic [63:0] pat_low_q;
	logic [63:0] pat_high_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[flwnm_pkg::ADDR_SEL])
				flwnm_pkg::REG_PAT_LOW:  pat_low_q  <= pwdata;
				flwnm_pkg::REG_PAT_HIGH: pat_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[flwnm_pkg::ADDR_SEL])
			flwnm_pkg::REG_PAT_LOW:  prdata = pat_low_q;
			flwnm_pkg::REG_PAT_HIGH: prdata = pat_high_q;
			default:                 prdata = '0;
		endcase
	end

	// User must change pattern only while idle, not enforced; length is taken off the registers.
	flwnm_pkg::str_t pat;
	flwnm_pkg::len_t plen;

	assign pat  = flwnm_pkg::str_t'({pat_high_q, pat_low_q});
	assign plen = flwnm_pkg::str_len(pat);

	// ---------------- stage enables ----------------
	// A stage loads when it is empty or its beat moves on this cycle.
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic en_s1;
	logic en_s2;
	logic en_out;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// ---------------- stage 1: name length ----------------
	flwnm_pkg::str_t name_in;
	flwnm_pkg::str_t name_s1;
	flwnm_pkg::len_t nlen_s1;

	assign name_in = flwnm_pkg::str_t'({name_high, name_low});

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			name_s1 <= name_in;
			nlen_s1 <= flwnm_pkg::str_len(name_in);
		end
	end

	// ---------------- stage 2: byte lanes ----------------
	// start: first name byte under the pattern tail in '*' mode (nlen - (plen - 1)).
	flwnm_pkg::len_t       start_full;
	flwnm_pkg::idx_t       start;
	flwnm_pkg::lane_vec_t  pos_ok;
	flwnm_pkg::lane_vec_t  star_ok;
	flwnm_pkg::lane_vec_t  pos_s2;
	flwnm_pkg::lane_vec_t  star_s2;
	flwnm_pkg::merge_ctrl_t ctrl_s2;

	assign start_full = nlen_s1 + flwnm_pkg::len_t'(1) - plen;
	assign start      = start_full[flwnm_pkg::IDX_W-1:0];

	for (genvar g = 0; g < flwnm_pkg::STR_BYTES; g++) begin : g_lane
		logic [7:0] pat_star;

		// the last lane never sits under the tail (tail is at most 15 bytes)
		if (g < flwnm_pkg::STR_BYTES - 1) begin : g_tail
			assign pat_star = pat[g+1];
		end else begin : g_last
			assign pat_star = flwnm_pkg::CHAR_NUL;
		end

		flwnm_lane u_lane (
			.lane_idx (flwnm_pkg::idx_t'(g)),
			.pat_pos  (pat[g]),
			.name_pos (name_s1[g]),
			.pat_star (pat_star),
			.name     (name_s1),
			.start    (start),
			.pos_ok   (pos_ok[g]),
			.star_ok  (star_ok[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			pos_s2        <= pos_ok;
			star_s2       <= star_ok;
			ctrl_s2.empty <= (pat[0] == flwnm_pkg::CHAR_NUL);
			ctrl_s2.star  <= (pat[0] == flwnm_pkg::CHAR_STAR);
			ctrl_s2.plen  <= plen;
			ctrl_s2.nlen  <= nlen_s1;
		end
	end

	// ---------------- stage 3: merge into output register ----------------
	logic merged;
	logic matched_q;

	flwnm_merge u_merge (
		.ctrl    (ctrl_s2),
		.pos_ok  (pos_s2),
		.star_ok (star_s2),
		.matched (merged)
	);

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			matched_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule

>>> design/flwnm_chk.sv
`include "assert_macros.svh"

module flwnm_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [flwnm_pkg::ADDR_W-1:0] paddr,
	input logic [63:0]                  pwdata,
	input logic [63:0]                  prdata,
	input logic                         pready,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         matched
);

	logic        wr_beat;
	logic        rd_same;
	logic        out_stall;
	logic        sel_q;
	logic [63:0] wdata_q;
	logic        readback_ok;

	assign wr_beat   = psel && penable && pwrite && pready;
	assign rd_same   = psel && !pwrite;
	assign out_stall = out_valid && !out_ready;

	// address and data of the previous cycle
	always_ff @(posedge clk) begin
		sel_q   <= paddr[flwnm_pkg::ADDR_SEL];
		wdata_q <= pwdata;
	end

	assign readback_ok = !rd_same || (paddr[flwnm_pkg::ADDR_SEL] != sel_q)
		|| (prdata == wdata_q);

	// stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(matched), "result moved")

	// input back-pressure only when every stage is full and the output is stalled
	`ASSERT_SAME(a_ready_cause, clk, arst_n, !in_ready, out_stall, "input stalled with room left")

	// a read straight after a write to the same register returns the written word
	`ASSERT_NEXT(a_readback, clk, arst_n, wr_beat, readback_ok, "register readback mismatch")

endmodule

bind fixed_length_wildcard_name_match flwnm_chk u_flwnm_chk (.*);
